### rtl/eisc_pkg.sv
// Shared constants and codes for the edge interrupt scan capture unit.
package eisc_pkg;

   localparam int unsigned NUM_SOURCES = 6;
   localparam int unsigned SRC_W       = 6;
   localparam int unsigned LIST_SLOTS  = 6;
   localparam int unsigned SRC_NUM_W   = 3;
   localparam int unsigned LEN_W       = 3;
   localparam int unsigned MAP_W       = LIST_SLOTS * SRC_NUM_W;
   localparam int unsigned COUNT_W     = 24;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [SRC_W-1:0] SRC_MASK = SRC_W'((1 << NUM_SOURCES) - 1);
   localparam logic [SRC_W-1:0] VALID_MASK_RESET = 6'h3F;
   localparam logic [LEN_W-1:0] LIST_LENGTH_RESET = 3'd1;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_START  = 2'd1,
      CMD_CANCEL = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      EVT_SCAN     = 2'd0,
      EVT_SCAN_END = 2'd1,
      EVT_EMPTY    = 2'd2,
      EVT_OVERRUN  = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VALID_MASK  = 3'd0,
      REG_CHANNEL_MAP = 3'd1,
      REG_LIST_LENGTH = 3'd2,
      REG_CONTINUOUS  = 3'd3,
      REG_STOP_LIMIT  = 3'd4
   } reg_index_type;

endpackage

### rtl/eisc_list_decode.sv
// Channel list decoder: source enable mask and list-position packing of triggered bits.
module eisc_list_decode (
   input  logic [eisc_pkg::MAP_W-1:0] channel_map,
   input  logic [eisc_pkg::LEN_W-1:0] list_length,
   input  logic [eisc_pkg::SRC_W-1:0] trig,
   output logic [eisc_pkg::SRC_W-1:0] list_mask,
   output logic [eisc_pkg::SRC_W-1:0] scan_bits
);

   logic [eisc_pkg::LEN_W-1:0] used;

   assign used = (list_length > eisc_pkg::LEN_W'(eisc_pkg::LIST_SLOTS)) ?
                 eisc_pkg::LEN_W'(eisc_pkg::LIST_SLOTS) : list_length;

   always_comb begin
      logic [eisc_pkg::SRC_NUM_W-1:0] src;
      logic [7:0]                     onehot;
      logic [eisc_pkg::SRC_W-1:0]     sbit;
      list_mask = '0;
      scan_bits = '0;
      for (int n = 0; n < int'(eisc_pkg::LIST_SLOTS); n++) begin
         src    = channel_map[n*eisc_pkg::SRC_NUM_W +: eisc_pkg::SRC_NUM_W];
         onehot = 8'(1) << src;
         sbit   = onehot[eisc_pkg::SRC_W-1:0] & eisc_pkg::SRC_MASK;
         if (eisc_pkg::LEN_W'(n) < used) begin
            list_mask = list_mask | sbit;
            scan_bits[n] = |(trig & sbit);
         end
      end
   end

endmodule

### rtl/edge_interrupt_scan_capture_unit.sv
// Top level of the edge interrupt scan capture unit.
//
// Request channel (req_*): one beat per command. A tick carries the source
// levels and the downstream buffer state; start and cancel ignore them.
// Response channel (rsp_*): at most one beat per request, giving the event
// code, the scan word packed by list position and the raw triggered bits.
// Configuration (csr_*): register writes by index, always ready; write only
// while no request is in flight.
// A request is taken into an input register, evaluated in one pass, and
// its response, if any, is registered in the output register. Throughput
// is one request per cycle while rsp_stall holds no waiting response; only
// the output register stage bounds it.
// When rsp_stall holds a waiting response, the input register keeps its
// beat and req_stall rises once that register is occupied.
// Reset (synchronous) restores the register defaults, stops acquisition,
// clears edge history and status, and empties both register stages.
module edge_interrupt_scan_capture_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [eisc_pkg::SRC_W-1:0]        req_source_levels,
   input  logic                              req_buffer_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_event_code,
   output logic [eisc_pkg::SRC_W-1:0]        rsp_scan_bits,
   output logic [eisc_pkg::SRC_W-1:0]        rsp_triggered_sources,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [eisc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [eisc_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned SW = eisc_pkg::SRC_W;
   localparam int unsigned CW = eisc_pkg::COUNT_W;

   // configuration
   logic [SW-1:0]                 valid_mask_ff;
   logic [eisc_pkg::MAP_W-1:0]    channel_map_ff;
   logic [eisc_pkg::LEN_W-1:0]    list_length_ff;
   logic                          continuous_ff;
   logic [CW-1:0]                 stop_limit_ff;

   // input stage
   logic                          stage_valid_ff, stage_valid_in;
   logic [1:0]                    stage_cmd_ff;
   logic [SW-1:0]                 stage_levels_ff;
   logic                          stage_ready_ff;
   logic                          stage_go;
   logic                          req_take;

   // acquisition state
   logic [SW-1:0]                 prev_ff, prev_in;
   logic [SW-1:0]                 status_ff, status_in;
   logic [SW-1:0]                 enabled_ff, enabled_in;
   logic                          running_ff, running_in;
   logic [CW-1:0]                 scans_left_ff, scans_left_in;

   // output stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_code_ff, rsp_code_in;
   logic [SW-1:0]                 rsp_bits_ff, rsp_bits_in;
   logic [SW-1:0]                 rsp_trig_ff, rsp_trig_in;
   logic                          has_result;

   logic [SW-1:0]                 levels;
   logic [SW-1:0]                 status_set;
   logic [SW-1:0]                 trig;
   logic [SW-1:0]                 list_mask;
   logic [SW-1:0]                 scan_bits;
   logic [CW-1:0]                 scans_dec;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_mask_ff  <= eisc_pkg::VALID_MASK_RESET;
         channel_map_ff <= '0;
         list_length_ff <= eisc_pkg::LIST_LENGTH_RESET;
         continuous_ff  <= 1'b0;
         stop_limit_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            eisc_pkg::REG_VALID_MASK:  valid_mask_ff  <= csr_data[SW-1:0];
            eisc_pkg::REG_CHANNEL_MAP: channel_map_ff <= csr_data[eisc_pkg::MAP_W-1:0];
            eisc_pkg::REG_LIST_LENGTH: list_length_ff <= csr_data[eisc_pkg::LEN_W-1:0];
            eisc_pkg::REG_CONTINUOUS:  continuous_ff  <= csr_data[0];
            eisc_pkg::REG_STOP_LIMIT:  stop_limit_ff  <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   assign stage_go  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stage_valid_ff && !stage_go;
   assign req_take  = req_valid && !req_stall;

   assign levels     = stage_levels_ff & eisc_pkg::SRC_MASK;
   assign status_set = (status_ff | (levels & ~prev_ff & enabled_ff)) & eisc_pkg::SRC_MASK;
   assign trig       = status_set & valid_mask_ff;
   assign scans_dec  = scans_left_ff - CW'(1);

   eisc_list_decode u_list (
      .channel_map (channel_map_ff),
      .list_length (list_length_ff),
      .trig        (trig),
      .list_mask   (list_mask),
      .scan_bits   (scan_bits)
   );

   always_comb begin
      logic          stop;
      logic [1:0]    code;
      logic [SW-1:0] en_new;
      stop           = 1'b0;
      code           = eisc_pkg::EVT_SCAN;
      en_new         = list_mask & valid_mask_ff & eisc_pkg::SRC_MASK;
      stage_valid_in = req_stall ? stage_valid_ff : req_valid;
      prev_in        = prev_ff;
      status_in      = status_ff;
      enabled_in     = enabled_ff;
      running_in     = running_ff;
      scans_left_in  = scans_left_ff;
      has_result     = 1'b0;
      rsp_code_in    = rsp_code_ff;
      rsp_bits_in    = rsp_bits_ff;
      rsp_trig_in    = rsp_trig_ff;

      if (stage_valid_ff && stage_go) begin
         unique case (stage_cmd_ff)
            eisc_pkg::CMD_START: begin
               if (!continuous_ff && stop_limit_ff == '0) begin
                  running_in    = 1'b0;
                  scans_left_in = '0;
                  has_result    = 1'b1;
                  rsp_code_in   = eisc_pkg::EVT_EMPTY;
                  rsp_bits_in   = '0;
                  rsp_trig_in   = '0;
               end else begin
                  running_in    = 1'b1;
                  scans_left_in = continuous_ff ? '0 : stop_limit_ff;
                  enabled_in    = en_new;
                  status_in     = status_ff & en_new;
               end
            end
            eisc_pkg::CMD_CANCEL: begin
               if (running_ff) begin
                  running_in = 1'b0;
                  enabled_in = '0;
                  status_in  = '0;
               end
            end
            eisc_pkg::CMD_TICK: begin
               prev_in   = levels;
               status_in = status_set & ~trig;
               if (trig != '0 && running_ff && (trig & enabled_ff) != '0) begin
                  if (!stage_ready_ff) begin
                     stop = 1'b1;
                     code = eisc_pkg::EVT_OVERRUN;
                  end
                  if (!continuous_ff && scans_left_ff != '0) begin
                     scans_left_in = scans_dec;
                     if (scans_dec == '0) begin
                        stop = 1'b1;
                        if (code == eisc_pkg::EVT_SCAN) code = eisc_pkg::EVT_SCAN_END;
                     end
                  end
                  if (stop) begin
                     running_in = 1'b0;
                     enabled_in = '0;
                     status_in  = '0;
                  end
                  has_result  = 1'b1;
                  rsp_code_in = code;
                  rsp_bits_in = scan_bits;
                  rsp_trig_in = trig;
               end
            end
            default: ;
         endcase
      end

      rsp_valid_in = (rsp_valid_ff && rsp_stall) ? 1'b1 : has_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         prev_ff        <= '0;
         status_ff      <= '0;
         enabled_ff     <= '0;
         running_ff     <= 1'b0;
         scans_left_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         prev_ff        <= prev_in;
         status_ff      <= status_in;
         enabled_ff     <= enabled_in;
         running_ff     <= running_in;
         scans_left_ff  <= scans_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_cmd_ff    <= req_command;
         stage_levels_ff <= req_source_levels;
         stage_ready_ff  <= req_buffer_ready;
      end
      if (has_result) begin
         rsp_code_ff <= rsp_code_in;
         rsp_bits_ff <= rsp_bits_in;
         rsp_trig_ff <= rsp_trig_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_code        = rsp_code_ff;
   assign rsp_scan_bits         = rsp_bits_ff;
   assign rsp_triggered_sources = rsp_trig_ff;

endmodule
